// ===== design/tasmg_pkg.sv =====
// Package for the three-axis step generator: operation codes, default sizes,
// register reset value and the control bundle sent to each axis slice.
// No dependencies.
package tasmg_pkg;

  localparam int POS_BITS_DEF  = 32;
  localparam int RATE_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int CFG_W         = 16;
  localparam int OP_W          = 2;
  localparam int PHASE_SHIFT   = 2;   // accel / decel ramps are a quarter of the move

  localparam logic [CFG_W-1:0] RESET_INTERVAL = 16'd50;

  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_START   = 2'd1;
  localparam logic [OP_W-1:0] OP_SET_POS = 2'd2;

  // Per-transaction strobes for an axis slice, already qualified by advance.
  typedef struct packed {
    logic start;
    logic set_pos;
    logic tick;
    logic slot;
  } axis_ctrl_t;

endpackage

// ===== design/tasmg_axis.sv =====
// One axis of the step generator: position, Bresenham delta/error, direction
// and step pulse. Depends on tasmg_pkg.
module tasmg_axis #(
  parameter int POS_BITS = tasmg_pkg::POS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tasmg_pkg::axis_ctrl_t  ctrl,
  input  logic [POS_BITS-1:0]    coord,
  input  logic [POS_BITS-1:0]    total,
  output logic [POS_BITS-1:0]    mag,
  output logic [POS_BITS-1:0]    position,
  output logic                   dir,
  output logic                   pulse
);
  import tasmg_pkg::*;

  logic [POS_BITS-1:0] delta;
  logic [POS_BITS-1:0] error;
  logic [POS_BITS:0]   diff_fwd;
  logic [POS_BITS:0]   diff_rev;
  logic                dir_next;
  logic [POS_BITS:0]   err_sum;
  logic [POS_BITS:0]   err_sub;
  logic                hit;
  logic [POS_BITS-1:0] error_next;
  logic [POS_BITS-1:0] pos_step;

  // Signed distance to the target, both ways round so abs is a select.
  assign diff_fwd = {coord[POS_BITS-1], coord} - {position[POS_BITS-1], position};
  assign diff_rev = {position[POS_BITS-1], position} - {coord[POS_BITS-1], coord};
  assign dir_next = ~diff_fwd[POS_BITS];
  assign mag      = dir_next ? diff_fwd[POS_BITS-1:0] : diff_rev[POS_BITS-1:0];

  // Bresenham: error stays below total, so the sum fits one extra bit.
  assign err_sum    = {1'b0, error} + {1'b0, delta};
  assign err_sub    = err_sum - {1'b0, total};
  assign hit        = (delta != '0) && (err_sum >= {1'b0, total});
  assign error_next = hit ? err_sub[POS_BITS-1:0] : err_sum[POS_BITS-1:0];
  assign pos_step   = dir ? position + POS_BITS'(1) : position - POS_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      delta    <= '0;
      error    <= '0;
      dir      <= 1'b1;
      pulse    <= 1'b0;
    end else begin
      if (ctrl.start) begin
        delta <= mag;
        error <= '0;
        dir   <= dir_next;
      end else if (ctrl.set_pos) begin
        position <= coord;
      end else if (ctrl.tick) begin
        pulse <= ctrl.slot & hit;
        if (ctrl.slot) begin
          error <= error_next;
          if (hit) begin
            position <= pos_step;
          end
        end
      end
    end
  end

  a_err_below_total: assert property (@(posedge clk) disable iff (rst)
    (delta != '0) |-> (error < total))
    else $error("axis error not below major total");

  a_pulse_from_slot: assert property (@(posedge clk) disable iff (rst)
    $rose(pulse) |-> $past(ctrl.slot))
    else $error("step pulse raised without a step slot");

endmodule

// ===== design/three_axis_stepper_motion_generator_top.sv =====
// Top level of the three-axis Bresenham step generator with trapezoidal rate.
// Depends on tasmg_pkg and tasmg_axis.
//
// channel | handshake              | payload
// --------+------------------------+-----------------------------------------
// in      | in_valid / in_stall    | operation, coord_x, coord_y, coord_z
// out     | out_valid / out_stall  | step_*, dir_*, busy_res, pos_*
// cfg     | cfg_valid / cfg_ready  | cfg_data (start_interval)
//
// One transaction per cycle sustained while out_stall is low. Path: input
// register, then the state update, whose registers also hold the result.
// The longest path is the start planning (signed diff, abs, max of three,
// quarter split) or the tick path (error add, compare with total, position +-1).
// Reset (rst, synchronous) gives zero positions, idle, interval 50.
// With out_stall high while a result is valid the state is frozen; one input
// transaction waits in the input register before in_stall rises.
module three_axis_stepper_motion_generator_top #(
  parameter int POS_BITS  = tasmg_pkg::POS_BITS_DEF,
  parameter int RATE_BITS = tasmg_pkg::RATE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tasmg_pkg::OP_W-1:0]           operation,
  input  logic signed [tasmg_pkg::COORD_W-1:0] coord_x,
  input  logic signed [tasmg_pkg::COORD_W-1:0] coord_y,
  input  logic signed [tasmg_pkg::COORD_W-1:0] coord_z,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 step_x,
  output logic                                 step_y,
  output logic                                 step_z,
  output logic                                 dir_x,
  output logic                                 dir_y,
  output logic                                 dir_z,
  output logic                                 busy_res,
  output logic signed [tasmg_pkg::COORD_W-1:0] pos_x,
  output logic signed [tasmg_pkg::COORD_W-1:0] pos_y,
  output logic signed [tasmg_pkg::COORD_W-1:0] pos_z,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tasmg_pkg::CFG_W-1:0]          cfg_data
);
  import tasmg_pkg::*;

  localparam int CMP_W = (RATE_BITS > CFG_W) ? RATE_BITS : CFG_W;
  localparam logic [RATE_BITS-1:0] RATE_MAX = {RATE_BITS{1'b1}};

  // ---------------------------------------------------------------- input stage
  logic                s1_valid;
  logic [OP_W-1:0]     s1_op;
  logic [POS_BITS-1:0] s1_cx;
  logic [POS_BITS-1:0] s1_cy;
  logic [POS_BITS-1:0] s1_cz;
  logic                advance;

  // advance: the held transaction is applied to the state this edge
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op <= operation;
      s1_cx <= coord_x[POS_BITS-1:0];
      s1_cy <= coord_y[POS_BITS-1:0];
      s1_cz <= coord_z[POS_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------- config reg
  logic [CFG_W-1:0] start_cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_cfg <= RESET_INTERVAL;
    end else if (cfg_valid && cfg_ready) begin
      start_cfg <= cfg_data;
    end
  end

  // Interval loaded at start: zero reads as 1, clipped to the counter range.
  logic [CMP_W-1:0]     cfg_ext;
  logic [RATE_BITS-1:0] load_interval;

  assign cfg_ext = CMP_W'(start_cfg);

  always_comb begin
    if (start_cfg == '0) begin
      load_interval = RATE_BITS'(1);
    end else if (cfg_ext > CMP_W'(RATE_MAX)) begin
      load_interval = RATE_MAX;
    end else begin
      load_interval = cfg_ext[RATE_BITS-1:0];
    end
  end

  // ------------------------------------------------------------ profile state
  logic [POS_BITS-1:0]  total_steps;
  logic [POS_BITS-1:0]  steps_left;
  logic [POS_BITS-1:0]  phase_count;
  logic [POS_BITS-1:0]  accel_end;
  logic [POS_BITS-1:0]  decel_begin;
  logic [RATE_BITS-1:0] interval;
  logic [RATE_BITS-1:0] tick_count;

  logic                 do_start;
  logic                 do_set;
  logic                 do_tick;
  logic                 busy;
  logic [RATE_BITS-1:0] tick_inc;
  logic                 slot;
  logic [POS_BITS-1:0]  phase_inc;
  logic [POS_BITS-1:0]  mag_x;
  logic [POS_BITS-1:0]  mag_y;
  logic [POS_BITS-1:0]  mag_z;
  logic [POS_BITS-1:0]  mag_xy;
  logic [POS_BITS-1:0]  major;
  logic [POS_BITS-1:0]  major_quarter;
  axis_ctrl_t           ctrl;

  assign do_start = advance && (s1_op == OP_START);
  assign do_set   = advance && (s1_op == OP_SET_POS);
  assign do_tick  = advance && (s1_op == OP_TICK);
  assign busy     = (steps_left != '0);

  // A tick while busy counts toward the interval; reaching it opens a step slot.
  assign tick_inc  = tick_count + RATE_BITS'(1);
  assign slot      = do_tick && busy && (tick_inc >= interval);
  assign phase_inc = phase_count + POS_BITS'(1);

  // Major axis count and the quarter points of the ramp.
  assign mag_xy        = (mag_x > mag_y) ? mag_x : mag_y;
  assign major         = (mag_z > mag_xy) ? mag_z : mag_xy;
  assign major_quarter = major >> PHASE_SHIFT;

  assign ctrl.start   = do_start;
  assign ctrl.set_pos = do_set;
  assign ctrl.tick    = do_tick;
  assign ctrl.slot    = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_steps <= '0;
      steps_left  <= '0;
      phase_count <= '0;
      accel_end   <= '0;
      decel_begin <= '0;
      interval    <= RATE_BITS'(RESET_INTERVAL);
      tick_count  <= '0;
    end else if (do_start) begin
      total_steps <= major;
      steps_left  <= major;
      phase_count <= '0;
      accel_end   <= major_quarter;
      decel_begin <= major - major_quarter;
      interval    <= load_interval;
      tick_count  <= '0;
    end else if (do_tick && busy) begin
      if (slot) begin
        tick_count  <= '0;
        phase_count <= phase_inc;
        steps_left  <= steps_left - POS_BITS'(1);
        // speed up in the first quarter, slow down in the last
        if (phase_inc < accel_end) begin
          if (interval > RATE_BITS'(1)) begin
            interval <= interval - RATE_BITS'(1);
          end
        end else if (phase_inc >= decel_begin) begin
          if (interval != RATE_MAX) begin
            interval <= interval + RATE_BITS'(1);
          end
        end
      end else begin
        tick_count <= tick_inc;
      end
    end
  end

  // ---------------------------------------------------------------- axes
  logic [POS_BITS-1:0] position_x;
  logic [POS_BITS-1:0] position_y;
  logic [POS_BITS-1:0] position_z;

  tasmg_axis #(.POS_BITS(POS_BITS)) u_axis_x (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .coord    (s1_cx),
    .total    (total_steps),
    .mag      (mag_x),
    .position (position_x),
    .dir      (dir_x),
    .pulse    (step_x)
  );

  tasmg_axis #(.POS_BITS(POS_BITS)) u_axis_y (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .coord    (s1_cy),
    .total    (total_steps),
    .mag      (mag_y),
    .position (position_y),
    .dir      (dir_y),
    .pulse    (step_y)
  );

  tasmg_axis #(.POS_BITS(POS_BITS)) u_axis_z (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .coord    (s1_cz),
    .total    (total_steps),
    .mag      (mag_z),
    .position (position_z),
    .dir      (dir_z),
    .pulse    (step_z)
  );

  // The state registers are the result register: they only move on advance,
  // which never happens while a result is held by out_stall.
  assign busy_res = busy;
  assign pos_x    = COORD_W'($signed(position_x));
  assign pos_y    = COORD_W'($signed(position_y));
  assign pos_z    = COORD_W'($signed(position_z));

  // ---------------------------------------------------------------- checks
  a_interval_nonzero: assert property (@(posedge clk) disable iff (rst)
    interval != '0)
    else $error("step interval reached zero");

  a_tick_below_interval: assert property (@(posedge clk) disable iff (rst)
    tick_count < interval)
    else $error("tick count not below interval");

  a_phase_plus_left: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, phase_count} + {1'b0, steps_left}) == {1'b0, total_steps})
    else $error("phase count and steps left disagree with total");

endmodule
